// ===== design/qau_pkg.sv =====
// Shared codes and types of the quaternion arithmetic unit.
package qau_pkg;

  localparam int IO_BITS = 16;

  typedef logic [1:0]         func_t;
  typedef logic [1:0]         status_t;
  typedef logic [IO_BITS-1:0] io_word_t;

  localparam func_t FUNC_MUL  = 2'd0;
  localparam func_t FUNC_MAT  = 2'd1;
  localparam func_t FUNC_NORM = 2'd2;
  localparam func_t FUNC_DOT  = 2'd3;

  localparam status_t STATUS_OK   = 2'd0;
  localparam status_t STATUS_ZERO = 2'd1;
  localparam status_t STATUS_SAT  = 2'd2;

endpackage

// ===== design/qau_if.sv =====
// Valid/ready channel interfaces for the input and result words.
interface qau_in_if;
  logic                   valid;
  logic                   ready;
  qau_pkg::func_t         func;
  logic signed [15:0]     a_w;
  logic signed [15:0]     a_x;
  logic signed [15:0]     a_y;
  logic signed [15:0]     a_z;
  logic signed [15:0]     b_w;
  logic signed [15:0]     b_x;
  logic signed [15:0]     b_y;
  logic signed [15:0]     b_z;
  modport source (output valid, func, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, input ready);
  modport sink (input valid, func, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, output ready);
endinterface

interface qau_out_if;
  logic                   valid;
  logic                   ready;
  logic signed [15:0]     res_0;
  logic signed [15:0]     res_1;
  logic signed [15:0]     res_2;
  logic signed [15:0]     res_3;
  logic signed [15:0]     res_4;
  logic signed [15:0]     res_5;
  logic signed [15:0]     res_6;
  logic signed [15:0]     res_7;
  logic signed [15:0]     res_8;
  qau_pkg::status_t       status;
  modport source (output valid, res_0, res_1, res_2, res_3, res_4, res_5, res_6, res_7,
                  res_8, status, input ready);
  modport sink (input valid, res_0, res_1, res_2, res_3, res_4, res_5, res_6, res_7,
                res_8, status, output ready);
endinterface

// ===== design/qau_front.sv =====
// Front pipeline: operand capture, products, exact sums, rounding and saturation.
module qau_front #(
  parameter int FRAC_BITS = 14,
  parameter int WORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  qau_pkg::func_t            in_func,
  input  qau_pkg::io_word_t         a_in [4],
  input  qau_pkg::io_word_t         b_in [4],
  output logic                      out_valid,
  output qau_pkg::func_t            out_func,
  output qau_pkg::io_word_t         res [9],
  output logic                      sat,
  output logic [2*WORD_BITS:0]      n_sq,
  output logic [WORD_BITS-1:0]      absv [4],
  output logic [3:0]                sgn
);
  import qau_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int SW = ((2 * W > 2 * F) ? 2 * W : 2 * F) + 4;
  localparam logic signed [SW-1:0] ONE_S  = SW'(1);
  localparam logic signed [SW-1:0] HALF_S = ONE_S <<< (F - 1);
  localparam logic signed [SW-1:0] ONE2_S = ONE_S <<< (2 * F);
  localparam logic signed [SW-1:0] WMAX_S = (ONE_S <<< (W - 1)) - ONE_S;
  localparam logic signed [SW-1:0] WMIN_S = -WMAX_S - ONE_S;

  function automatic logic signed [W-1:0] ext_word(input io_word_t f);
    logic [W-1:0] v;
    v = '0;
    for (int i = 0; i < IO_BITS; i++) begin
      if (i < W) v[i] = f[i];
    end
    return $signed(v);
  endfunction

  function automatic io_word_t to16(input logic [W-1:0] v);
    io_word_t o;
    o = '0;
    for (int i = 0; i < IO_BITS; i++) begin
      if (i < W) o[i] = v[i];
    end
    return o;
  endfunction

  // Stage 1: operands. Matrix and normalize square a, so b takes a.
  logic                v1_r;
  func_t               func1_r;
  logic signed [W-1:0] a1_r [4];
  logic signed [W-1:0] b1_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func1_r <= in_func;
      for (int i = 0; i < 4; i++) begin
        a1_r[i] <= ext_word(a_in[i]);
        b1_r[i] <= (in_func == FUNC_MAT || in_func == FUNC_NORM) ? ext_word(a_in[i])
                                                                 : ext_word(b_in[i]);
      end
    end
  end

  // Stage 2: all sixteen cross products.
  logic                 v2_r;
  func_t                func2_r;
  logic signed [W-1:0]  a2_r [4];
  logic signed [PW-1:0] p2_r [4][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func2_r <= func1_r;
      for (int i = 0; i < 4; i++) begin
        a2_r[i] <= a1_r[i];
        for (int j = 0; j < 4; j++) begin
          p2_r[i][j] <= a1_r[i] * b1_r[j];
        end
      end
    end
  end

  // Stage 3: exact sums scaled to 2^-2F.
  logic signed [SW-1:0] pe [4][4];
  logic signed [SW-1:0] s_nxt [9];
  logic                 v3_r;
  func_t                func3_r;
  logic signed [SW-1:0] s3_r [9];
  logic [W-1:0]         abs3_r [4];
  logic [3:0]           sgn3_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pe[i][j] = SW'(p2_r[i][j]);
      end
    end
    for (int i = 0; i < 9; i++) s_nxt[i] = '0;
    unique case (func2_r)
      FUNC_MUL: begin
        s_nxt[0] = pe[0][0] - pe[1][1] - pe[2][2] - pe[3][3];
        s_nxt[1] = pe[0][1] + pe[1][0] + pe[2][3] - pe[3][2];
        s_nxt[2] = pe[0][2] - pe[1][3] + pe[2][0] + pe[3][1];
        s_nxt[3] = pe[0][3] + pe[1][2] - pe[2][1] + pe[3][0];
      end
      FUNC_MAT: begin
        s_nxt[0] = ONE2_S - ((pe[2][2] + pe[3][3]) <<< 1);
        s_nxt[1] = (pe[1][2] + pe[0][3]) <<< 1;
        s_nxt[2] = (pe[1][3] - pe[0][2]) <<< 1;
        s_nxt[3] = (pe[1][2] - pe[0][3]) <<< 1;
        s_nxt[4] = ONE2_S - ((pe[1][1] + pe[3][3]) <<< 1);
        s_nxt[5] = (pe[2][3] + pe[0][1]) <<< 1;
        s_nxt[6] = (pe[1][3] + pe[0][2]) <<< 1;
        s_nxt[7] = (pe[2][3] - pe[0][1]) <<< 1;
        s_nxt[8] = ONE2_S - ((pe[1][1] + pe[2][2]) <<< 1);
      end
      FUNC_NORM, FUNC_DOT: begin
        s_nxt[0] = pe[0][0] + pe[1][1] + pe[2][2] + pe[3][3];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func3_r <= func2_r;
      for (int i = 0; i < 9; i++) s3_r[i] <= s_nxt[i];
      for (int i = 0; i < 4; i++) begin
        abs3_r[i] <= a2_r[i][W-1] ? W'(-a2_r[i]) : W'(a2_r[i]);
        sgn3_r[i] <= a2_r[i][W-1];
      end
    end
  end

  // Stage 4: round half up, then clamp to the word.
  logic signed [SW-1:0] rnd [9];
  logic [W-1:0]         word [9];
  logic [8:0]           flag;
  logic                 v4_r;
  func_t                func4_r;
  io_word_t             res4_r [9];
  logic                 sat4_r;
  logic [2*W:0]         n4_r;
  logic [W-1:0]         abs4_r [4];
  logic [3:0]           sgn4_r;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      rnd[i] = (s3_r[i] + HALF_S) >>> F;
      if (rnd[i] > WMAX_S) begin
        word[i] = WMAX_S[W-1:0];
        flag[i] = 1'b1;
      end else if (rnd[i] < WMIN_S) begin
        word[i] = WMIN_S[W-1:0];
        flag[i] = 1'b1;
      end else begin
        word[i] = rnd[i][W-1:0];
        flag[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func4_r <= func3_r;
      for (int i = 0; i < 9; i++) res4_r[i] <= to16(word[i]);
      sat4_r <= |flag;
      n4_r   <= s3_r[0][2*W:0];
      abs4_r <= abs3_r;
      sgn4_r <= sgn3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_func  = func4_r;
  assign res       = res4_r;
  assign sat       = sat4_r;
  assign n_sq      = n4_r;
  assign absv      = abs4_r;
  assign sgn       = sgn4_r;

endmodule

// ===== design/qau_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module qau_sqrt #(
  parameter int WORD_BITS = 16,
  parameter int TAG_W     = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2*WORD_BITS:0] n_sq,
  input  logic [TAG_W-1:0]     tag_in,
  output logic                 out_valid,
  output logic [WORD_BITS:0]   root,
  output logic [TAG_W-1:0]     tag_out
);
  import qau_pkg::*;

  localparam int R  = WORD_BITS + 1;
  localparam int NB = 2 * R;

  logic             v_r    [R];
  logic [R+1:0]     rem_r  [R];
  logic [R-1:0]     root_r [R];
  logic [NB-1:0]    nsh_r  [R];
  logic [TAG_W-1:0] tag_r  [R];

  for (genvar j = 0; j < R; j++) begin : g_stg
    logic             v_i;
    logic [R+1:0]     rem_i;
    logic [R-1:0]     root_i;
    logic [NB-1:0]    nsh_i;
    logic [TAG_W-1:0] tag_i;
    logic [R+3:0]     remx;
    logic [R+3:0]     trial;
    logic             take;

    if (j == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = '0;
      assign root_i = '0;
      assign nsh_i  = NB'(n_sq);
      assign tag_i  = tag_in;
    end else begin : g_next
      assign v_i    = v_r[j-1];
      assign rem_i  = rem_r[j-1];
      assign root_i = root_r[j-1];
      assign nsh_i  = nsh_r[j-1];
      assign tag_i  = tag_r[j-1];
    end

    assign remx  = {rem_i, nsh_i[NB-1 -: 2]};
    assign trial = (R + 4)'({root_i, 2'b01});
    assign take  = (remx >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= take ? (R + 2)'(remx - trial) : (R + 2)'(remx);
        root_r[j] <= {root_i[R-2:0], take};
        nsh_r[j]  <= nsh_i << 2;
        tag_r[j]  <= tag_i;
      end
    end
  end

  assign out_valid = v_r[R-1];
  assign root      = root_r[R-1];
  assign tag_out   = tag_r[R-1];

endmodule

// ===== design/qau_div.sv =====
// Four-lane pipelined restoring divider, one quotient bit per stage.
module qau_div #(
  parameter int FRAC_BITS = 14,
  parameter int WORD_BITS = 16,
  parameter int TAG_W     = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [WORD_BITS:0]   mag,
  input  logic [WORD_BITS-1:0] absv [4],
  input  logic [TAG_W-1:0]     tag_in,
  output logic                 out_valid,
  output logic [FRAC_BITS:0]   quo [4],
  output logic [TAG_W-1:0]     tag_out
);
  import qau_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int QB = F + 1;
  localparam int NW = W + F + 2;

  logic             v_r   [QB];
  logic [NW-1:0]    rem_r [QB][4];
  logic [QB-1:0]    q_r   [QB][4];
  logic [W+1:0]     d_r   [QB];
  logic [TAG_W-1:0] tag_r [QB];

  for (genvar j = 0; j < QB; j++) begin : g_stg
    localparam int K = QB - 1 - j;
    logic             v_i;
    logic [NW-1:0]    rem_i [4];
    logic [QB-1:0]    q_i   [4];
    logic [W+1:0]     d_i;
    logic [TAG_W-1:0] tag_i;
    logic [NW-1:0]    dk;
    logic [NW-1:0]    rem_n [4];
    logic [QB-1:0]    q_n   [4];

    if (j == 0) begin : g_first
      // Dividend |c|*2^(F+1) + mag over divisor 2*mag rounds half away from zero.
      assign v_i   = in_valid;
      assign d_i   = {mag, 1'b0};
      assign tag_i = tag_in;
      always_comb begin
        for (int l = 0; l < 4; l++) begin
          rem_i[l] = (NW'(absv[l]) << (F + 1)) + NW'(mag);
          q_i[l]   = '0;
        end
      end
    end else begin : g_next
      assign v_i   = v_r[j-1];
      assign rem_i = rem_r[j-1];
      assign q_i   = q_r[j-1];
      assign d_i   = d_r[j-1];
      assign tag_i = tag_r[j-1];
    end

    assign dk = NW'(d_i) << K;

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        if (rem_i[l] >= dk) begin
          rem_n[l] = rem_i[l] - dk;
          q_n[l]   = q_i[l] | (QB'(1) << K);
        end else begin
          rem_n[l] = rem_i[l];
          q_n[l]   = q_i[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_n;
        q_r[j]   <= q_n;
        d_r[j]   <= d_i;
        tag_r[j] <= tag_i;
      end
    end
  end

  assign out_valid = v_r[QB-1];
  assign quo       = q_r[QB-1];
  assign tag_out   = tag_r[QB-1];

endmodule

// ===== design/quaternion_arith_unit_top.sv =====
// Quaternion arithmetic unit: multiply, rotation matrix, normalize and dot product.
//
// One input word on in_ch carries a function code and two quaternions a and b
// in signed Q2.14; one result word on out_ch carries nine result fields and a
// status code. Every input word yields exactly one result word, in order.
// Throughput is one word per cycle for every function while no result is stalled;
// the pipeline has no feedback path, so back-to-back words flow without bubbles.
// The pipeline has four front stages (operands, products, sums, rounding),
// WORD_BITS+1 square-root stages, FRAC_BITS+1 divider stages and the output
// register. All functions take the same path so results leave in order.
// A zero-magnitude normalize returns the identity with status 1; any clamped
// result gives status 2.
// When out_ch.ready is low with a result waiting, the whole pipeline holds and
// in_ch.ready drops in the same cycle; nothing is lost or repeated.
// The synchronous reset rst_n empties the pipeline and clears out_ch.valid.
module quaternion_arith_unit_top #(
  parameter int FRAC_BITS = 14,
  parameter int WORD_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  qau_in_if.sink    in_ch,
  qau_out_if.source out_ch
);
  import qau_pkg::*;

  localparam int W      = WORD_BITS;
  localparam int F      = FRAC_BITS;
  localparam int QB     = F + 1;
  localparam int VW     = ((QB > W) ? QB : W) + 2;
  localparam int SIDE_W = 2 + 9 * IO_BITS + 1 + 4;
  localparam int STAG_W = SIDE_W + 4 * W;
  localparam int DTAG_W = SIDE_W + 1;
  localparam logic signed [VW-1:0] ONE_V  = VW'(1);
  localparam logic signed [VW-1:0] WMAX_V = (ONE_V <<< (W - 1)) - ONE_V;
  localparam logic signed [VW-1:0] WMIN_V = -WMAX_V - ONE_V;
  localparam logic signed [VW-1:0] UNIT_V = ONE_V <<< F;

  function automatic logic [W:0] clamp(input logic signed [VW-1:0] v);
    if (v > WMAX_V) return {1'b1, WMAX_V[W-1:0]};
    if (v < WMIN_V) return {1'b1, WMIN_V[W-1:0]};
    return {1'b0, v[W-1:0]};
  endfunction

  function automatic io_word_t to16(input logic [W-1:0] v);
    io_word_t o;
    o = '0;
    for (int i = 0; i < IO_BITS; i++) begin
      if (i < W) o[i] = v[i];
    end
    return o;
  endfunction

  logic en;
  logic ov_r;

  assign en          = !ov_r || out_ch.ready;
  assign in_ch.ready = en;

  // Front pipeline
  io_word_t     a_in [4];
  io_word_t     b_in [4];
  logic         f_valid;
  func_t        f_func;
  io_word_t     f_res [9];
  logic         f_sat;
  logic [2*W:0] f_n;
  logic [W-1:0] f_abs [4];
  logic [3:0]   f_sgn;

  assign a_in = '{in_ch.a_w, in_ch.a_x, in_ch.a_y, in_ch.a_z};
  assign b_in = '{in_ch.b_w, in_ch.b_x, in_ch.b_y, in_ch.b_z};

  qau_front #(.FRAC_BITS(F), .WORD_BITS(W)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .a_in      (a_in),
    .b_in      (b_in),
    .out_valid (f_valid),
    .out_func  (f_func),
    .res       (f_res),
    .sat       (f_sat),
    .n_sq      (f_n),
    .absv      (f_abs),
    .sgn       (f_sgn)
  );

  // Side data rides along the square root and divider pipelines.
  logic [SIDE_W-1:0] side;
  logic [STAG_W-1:0] s_tag_in;

  always_comb begin
    side = '0;
    side[3:0]          = f_sgn;
    side[4]            = f_sat;
    for (int i = 0; i < 9; i++) side[5 + i*IO_BITS +: IO_BITS] = f_res[i];
    side[SIDE_W-1 -: 2] = f_func;
    s_tag_in = '0;
    for (int l = 0; l < 4; l++) s_tag_in[l*W +: W] = f_abs[l];
    s_tag_in[STAG_W-1 -: SIDE_W] = side;
  end

  logic              s_valid;
  logic [W:0]        s_root;
  logic [STAG_W-1:0] s_tag;
  logic [W-1:0]      s_abs [4];
  logic [DTAG_W-1:0] d_tag_in;

  qau_sqrt #(.WORD_BITS(W), .TAG_W(STAG_W)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .n_sq      (f_n),
    .tag_in    (s_tag_in),
    .out_valid (s_valid),
    .root      (s_root),
    .tag_out   (s_tag)
  );

  always_comb begin
    for (int l = 0; l < 4; l++) s_abs[l] = s_tag[l*W +: W];
    d_tag_in = {s_tag[STAG_W-1 -: SIDE_W], (s_root == '0)};
  end

  logic              d_valid;
  logic [QB-1:0]     d_q [4];
  logic [DTAG_W-1:0] d_tag;

  qau_div #(.FRAC_BITS(F), .WORD_BITS(W), .TAG_W(DTAG_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s_valid),
    .mag       (s_root),
    .absv      (s_abs),
    .tag_in    (d_tag_in),
    .out_valid (d_valid),
    .quo       (d_q),
    .tag_out   (d_tag)
  );

  // Result selection and output register
  func_t                d_func;
  logic                 d_zero;
  logic                 d_sat;
  logic [3:0]           d_sgn;
  logic signed [VW-1:0] qv;
  logic [W:0]           cl;
  logic                 nflag;
  io_word_t             res_nxt [9];
  status_t              status_nxt;
  io_word_t             res_r [9];
  status_t              status_r;

  always_comb begin
    d_zero = d_tag[0];
    d_sgn  = d_tag[4:1];
    d_sat  = d_tag[5];
    d_func = d_tag[DTAG_W-1 -: 2];
    nflag  = 1'b0;
    qv     = '0;
    cl     = '0;
    for (int i = 0; i < 9; i++) res_nxt[i] = d_tag[6 + i*IO_BITS +: IO_BITS];
    status_nxt = d_sat ? STATUS_SAT : STATUS_OK;
    if (d_func == FUNC_NORM) begin
      for (int i = 0; i < 9; i++) res_nxt[i] = '0;
      if (d_zero) begin
        cl         = clamp(UNIT_V);
        res_nxt[0] = to16(cl[W-1:0]);
        status_nxt = STATUS_ZERO;
      end else begin
        for (int i = 0; i < 4; i++) begin
          qv         = $signed(VW'(d_q[i]));
          cl         = clamp(d_sgn[i] ? -qv : qv);
          res_nxt[i] = to16(cl[W-1:0]);
          nflag      = nflag | cl[W];
        end
        status_nxt = nflag ? STATUS_SAT : STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r    <= res_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid  = ov_r;
  assign out_ch.res_0  = res_r[0];
  assign out_ch.res_1  = res_r[1];
  assign out_ch.res_2  = res_r[2];
  assign out_ch.res_3  = res_r[3];
  assign out_ch.res_4  = res_r[4];
  assign out_ch.res_5  = res_r[5];
  assign out_ch.res_6  = res_r[6];
  assign out_ch.res_7  = res_r[7];
  assign out_ch.res_8  = res_r[8];
  assign out_ch.status = status_r;

endmodule

// ===== design/qau_chk.sv =====
// Port-level assertion checker for the quaternion unit and its bind.
module qau_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [15:0]       res_0,
  input logic [15:0]       res_1,
  input logic [15:0]       res_2,
  input logic [15:0]       res_3,
  input logic [15:0]       res_4,
  input logic [15:0]       res_5,
  input logic [15:0]       res_6,
  input logic [15:0]       res_7,
  input logic [15:0]       res_8,
  input qau_pkg::status_t  status
);
  import qau_pkg::*;

  // Reset empties the pipeline, so no word is offered right after it.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word offered after reset");

  // A stalled result must hold back the input side in the same cycle.
  a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while a result is stalled");

  // The identity returned for a zero magnitude has only a scalar part.
  a_zero_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == STATUS_ZERO |->
      res_1 == 16'd0 && res_2 == 16'd0 && res_3 == 16'd0 && res_4 == 16'd0 &&
      res_5 == 16'd0 && res_6 == 16'd0 && res_7 == 16'd0 && res_8 == 16'd0)
    else $error("zero-magnitude result has nonzero vector part");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({res_0, res_1, res_2, res_3, res_4, res_5, res_6, res_7, res_8, status}))
    else $error("stalled result word changed");

endmodule

bind quaternion_arith_unit_top qau_chk u_qau_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .res_0     (out_ch.res_0),
  .res_1     (out_ch.res_1),
  .res_2     (out_ch.res_2),
  .res_3     (out_ch.res_3),
  .res_4     (out_ch.res_4),
  .res_5     (out_ch.res_5),
  .res_6     (out_ch.res_6),
  .res_7     (out_ch.res_7),
  .res_8     (out_ch.res_8),
  .status    (out_ch.status)
);

// ===== tb/quaternion_arith_unit_top_test.sv =====
// Self-checking testbench for the quaternion arithmetic unit with its own fixed-point predictor.
module quaternion_arith_unit_top_test;
  import qau_pkg::*;

  typedef struct {
    func_t           func;
    logic signed [15:0] q [8];  // a_w a_x a_y a_z b_w b_x b_y b_z
  } quat_word_t;

  typedef struct {
    logic signed [15:0] res [9];
    status_t            status;
  } quat_result_t;

  localparam longint ONE_Q = 64'sd16384;
  localparam longint HALF_LSB = 64'sd8192;

  logic clk = 1'b0;
  logic rst_n;
  qau_in_if  in_ch ();
  qau_out_if out_ch ();

  quaternion_arith_unit_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  quat_result_t pending_results [$];
  int  error_count;
  int  words_sent;
  int  words_checked;
  bit  tx_idle_en;
  bit  rx_idle_en;
  int  rx_wait;
  int  func_seen [4];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint clamp_word(longint v, inout bit clipped);
    if (v > 32767) begin
      clipped = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      clipped = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  // Exact sum in units of 2^-28, rounded to a 2^-14 LSB with ties upward.
  function automatic longint round_q14(longint v);
    return (v + HALF_LSB) >>> 14;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic quat_result_t predict_quat(quat_word_t w);
    quat_result_t e;
    longint a [4];
    longint b [4];
    longint r [9];
    longint unsigned sumsq;
    longint unsigned mag;
    longint unsigned mq;
    bit clipped;
    bit zero_mag;
    for (int i = 0; i < 4; i++) begin
      a[i] = w.q[i];
      b[i] = w.q[i+4];
    end
    for (int i = 0; i < 9; i++) r[i] = 0;
    clipped = 1'b0;
    zero_mag = 1'b0;
    case (w.func)
      FUNC_MUL: begin
        r[0] = round_q14(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]);
        r[1] = round_q14(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]);
        r[2] = round_q14(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1]);
        r[3] = round_q14(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0]);
      end
      FUNC_MAT: begin
        // Diagonal entries are 1.0 - 2*(p0+p1); the others are 2*(p0+p1) or 2*(p0-p1).
        r[0] = round_q14((ONE_Q << 14) - 2*(a[2]*a[2] + a[3]*a[3]));
        r[1] = round_q14(2*(a[1]*a[2] + a[0]*a[3]));
        r[2] = round_q14(2*(a[1]*a[3] - a[0]*a[2]));
        r[3] = round_q14(2*(a[1]*a[2] - a[0]*a[3]));
        r[4] = round_q14((ONE_Q << 14) - 2*(a[1]*a[1] + a[3]*a[3]));
        r[5] = round_q14(2*(a[2]*a[3] + a[0]*a[1]));
        r[6] = round_q14(2*(a[1]*a[3] + a[0]*a[2]));
        r[7] = round_q14(2*(a[2]*a[3] - a[0]*a[1]));
        r[8] = round_q14((ONE_Q << 14) - 2*(a[1]*a[1] + a[2]*a[2]));
      end
      FUNC_NORM: begin
        sumsq = 0;
        for (int i = 0; i < 4; i++) sumsq += longint'(a[i]*a[i]);
        mag = int_sqrt(sumsq);
        if (mag == 0) begin
          zero_mag = 1'b1;
          r[0] = ONE_Q;
        end else begin
          // Divide with ties away from zero, then restore the sign.
          for (int i = 0; i < 4; i++) begin
            mq = ((64'(a[i] < 0 ? -a[i] : a[i]) << 14) * 2 + mag) / (2 * mag);
            r[i] = (a[i] < 0) ? -longint'(mq) : longint'(mq);
          end
        end
      end
      default: begin
        r[0] = round_q14(a[0]*b[0] + a[1]*b[1] + a[2]*b[2] + a[3]*b[3]);
      end
    endcase
    for (int i = 0; i < 9; i++) e.res[i] = 16'(clamp_word(r[i], clipped));
    if (zero_mag) e.status = STATUS_ZERO;
    else if (clipped) e.status = STATUS_SAT;
    else e.status = STATUS_OK;
    return e;
  endfunction

  // Sends one word; called and left at a rising edge, valid stays high afterwards.
  task automatic send_word(quat_word_t w);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= w.func;
    in_ch.a_w   <= w.q[0];
    in_ch.a_x   <= w.q[1];
    in_ch.a_y   <= w.q[2];
    in_ch.a_z   <= w.q[3];
    in_ch.b_w   <= w.q[4];
    in_ch.b_x   <= w.q[5];
    in_ch.b_y   <= w.q[6];
    in_ch.b_z   <= w.q[7];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(predict_quat(w));
    func_seen[w.func]++;
    words_sent++;
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_drain();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_component();
    int sel;
    sel = $urandom_range(0, 15);
    case (sel)
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return 16'sd16384;
      4: return -16'sd16384;
      5: return 16'(signed'($urandom_range(0, 6)) - 3);
      6, 7, 8: return 16'(signed'($urandom_range(0, 32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic quat_word_t make_word(func_t f, longint aw, longint ax, longint ay,
                                           longint az, longint bw, longint bx, longint by,
                                           longint bz);
    quat_word_t w;
    w.func = f;
    w.q[0] = 16'(aw); w.q[1] = 16'(ax); w.q[2] = 16'(ay); w.q[3] = 16'(az);
    w.q[4] = 16'(bw); w.q[5] = 16'(bx); w.q[6] = 16'(by); w.q[7] = 16'(bz);
    return w;
  endfunction

  task automatic test_directed_extremes();
    send_word(make_word(FUNC_MUL, 16384, 0, 0, 0, 16384, 0, 0, 0));
    send_word(make_word(FUNC_MUL, -32768, -32768, -32768, -32768,
                        -32768, -32768, -32768, -32768));
    send_word(make_word(FUNC_MUL, 32767, 32767, 32767, 32767, -32768, 32767, -32768, 32767));
    send_word(make_word(FUNC_MUL, 1, -1, 1, -1, 8192, 8192, -8192, 8192));
    send_word(make_word(FUNC_MAT, 16384, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(FUNC_MAT, 11585, 11585, 0, 0, 0, 0, 0, 0));
    send_word(make_word(FUNC_MAT, -32768, -32768, -32768, -32768, 0, 0, 0, 0));
    send_word(make_word(FUNC_MAT, 32767, 32767, 32767, 32767, 0, 0, 0, 0));
    send_word(make_word(FUNC_NORM, 3, 4, 0, 0, 0, 0, 0, 0));
    send_word(make_word(FUNC_NORM, -32768, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(FUNC_NORM, 32767, 32767, 32767, 32767, 0, 0, 0, 0));
    send_word(make_word(FUNC_NORM, -32768, -32768, -32768, -32768, 5, 5, 5, 5));
    send_word(make_word(FUNC_NORM, 1, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(FUNC_NORM, 0, 0, 0, -1, 0, 0, 0, 0));
    send_word(make_word(FUNC_DOT, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384));
    send_word(make_word(FUNC_DOT, -32768, -32768, -32768, -32768,
                        -32768, -32768, -32768, -32768));
    send_word(make_word(FUNC_DOT, 32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767));
    send_word(make_word(FUNC_DOT, 1, 1, 0, 0, 8192, 8192, 0, 0));
    stop_sending();
  endtask

  // A zero quaternion must normalize to the identity whatever b holds.
  task automatic test_zero_normalize();
    send_word(make_word(FUNC_NORM, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(FUNC_NORM, 0, 0, 0, 0, -32768, 32767, -1, 12345));
    stop_sending();
  endtask

  task automatic test_random_mix(int count);
    quat_word_t w;
    for (int n = 0; n < count; n++) begin
      w.func = func_t'($urandom_range(0, 3));
      for (int i = 0; i < 8; i++) w.q[i] = pick_component();
      if (w.func == FUNC_NORM && $urandom_range(0, 19) == 0)
        for (int i = 0; i < 4; i++) w.q[i] = 16'sd0;
      send_word(w);
    end
    stop_sending();
  endtask

  // The sender holds off until the pipeline has returned every result.
  task automatic test_drain_pause();
    test_random_mix(60);
    wait_for_drain();
    test_random_mix(60);
  endtask

  task automatic test_back_to_back();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_mix(300);
    rx_idle_en = 1'b1;
    test_random_mix(100);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b0;
    test_random_mix(100);
    rx_idle_en = 1'b1;
  endtask

  always @(posedge clk) begin : result_ready_gen
    int w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      w = rx_idle_en ? $urandom_range(0, 3) : 0;
      rx_wait <= w;
      out_ch.ready <= (w == 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_ch.ready <= (rx_wait == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    quat_result_t exp_r;
    logic signed [15:0] got [9];
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.res_0, out_ch.res_1, out_ch.res_2, out_ch.res_3, out_ch.res_4,
              out_ch.res_5, out_ch.res_6, out_ch.res_7, out_ch.res_8};
      if (pending_results.size() == 0) begin
        $display("%0t: result word with nothing expected", $time);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        words_checked++;
        for (int i = 0; i < 9; i++)
          if (got[i] !== exp_r.res[i]) begin
            $display("%0t: res_%0d expected %0d actual %0d", $time, i, exp_r.res[i], got[i]);
            error_count++;
          end
        if (out_ch.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, out_ch.status);
          error_count++;
        end
      end
    end
  end

  initial begin
    #(12 * 400000);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_MUL;
    in_ch.a_w = '0; in_ch.a_x = '0; in_ch.a_y = '0; in_ch.a_z = '0;
    in_ch.b_w = '0; in_ch.b_x = '0; in_ch.b_y = '0; in_ch.b_z = '0;
    error_count = 0;
    words_sent = 0;
    words_checked = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    for (int i = 0; i < 4; i++) func_seen[i] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_zero_normalize();
    test_drain_pause();
    test_back_to_back();
    test_random_mix(880);

    wait_for_drain();
    repeat (60) @(posedge clk);
    $display("Sent %0d words, checked %0d results (mul %0d, matrix %0d, norm %0d, dot %0d).",
             words_sent, words_checked, func_seen[0], func_seen[1], func_seen[2], func_seen[3]);
    $display("Covered operand extremes, zero-magnitude normalize, saturation and random stalls.");
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
